// File: design/hvdc_pkg.sv
// Shared constants for the hint vector decoder and checker.
package hvdc_pkg;

   localparam int NUM_POLYS_DEF  = 4;
   localparam int MAX_HINTS_DEF  = 80;
   localparam int COEFFS         = 256;
   localparam int WORD_BITS      = 64;
   localparam int WORDS_PER_POLY = COEFFS / WORD_BITS;
   localparam int BYTE_BITS      = 8;
   localparam int REQ_DATA_BITS  = 8;
   localparam int RSP_DATA_BITS  = 72;

endpackage

// File: design/hvdc_ram.sv
// Generic single-write, single-read RAM with registered read data.
module hvdc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: design/hint_vector_decoder_checker.sv
// Hint section decoder and checker: top level with its walk sequencer.
//
// Takes one hint section byte per request: MAX_HINTS position bytes, then one
// cumulative end count per polynomial. Loading runs at one byte per cycle.
// The last byte starts the decode, during which req_tready is low: each
// polynomial, and the unused byte pass, sets up its range in S_POLY and
// closes it in S_RD; each position walked takes a section RAM read, a bitmap
// read and a bitmap write (S_RD, S_POS, S_UPD), and each unused position byte
// checked takes a section RAM read and a check (S_RD, S_POS). Then the
// NUM_POLYS*4 bitmap words go out, each read, loaded and then held until
// rsp_tready, polynomial by polynomial, words ascending, with rsp_tlast on the
// final word. Bitmap words are cleared per signature through per-word valid
// bits, so no clearing pass is needed.
module hint_vector_decoder_checker
   import hvdc_pkg::*;
#(
   parameter int NUM_POLYS = NUM_POLYS_DEF,
   parameter int MAX_HINTS = MAX_HINTS_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  logic [REQ_DATA_BITS-1:0] req_tdata,  // [7:0] hint_byte
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   output logic [RSP_DATA_BITS-1:0] rsp_tdata,  // [63:0] bitmap_word, [65:64] poly_index,
                                                // [67:66] word_index, [71:68] zero
   output logic                     rsp_tuser,  // [0] malformed
   output logic                     rsp_tlast
);

   localparam int SECTION_LEN = MAX_HINTS + NUM_POLYS;
   localparam int TOTAL_WORDS = NUM_POLYS * WORDS_PER_POLY;
   localparam int CW  = $clog2(SECTION_LEN);
   localparam int HAW = (MAX_HINTS > 1) ? $clog2(MAX_HINTS) : 1;
   localparam int BAW = $clog2(TOTAL_WORDS);
   localparam int EW  = $clog2(TOTAL_WORDS + 1);
   localparam int PW  = (NUM_POLYS > 1) ? $clog2(NUM_POLYS) : 1;
   localparam int PCW = $clog2(NUM_POLYS + 1);

   localparam logic [2:0] S_LOAD      = 3'd0;
   localparam logic [2:0] S_POLY      = 3'd1;
   localparam logic [2:0] S_RD        = 3'd2;
   localparam logic [2:0] S_POS       = 3'd3;
   localparam logic [2:0] S_UPD       = 3'd4;
   localparam logic [2:0] S_EMIT_RD   = 3'd5;
   localparam logic [2:0] S_EMIT_LD   = 3'd6;
   localparam logic [2:0] S_EMIT_WAIT = 3'd7;

   logic [2:0]             state_ff, state_in;
   logic [CW-1:0]          cnt_ff, cnt_in;
   logic [TOTAL_WORDS-1:0] valid_ff, valid_in;
   logic                   err_ff, err_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [PCW-1:0]         p_ff, p_in;
   logic [EW-1:0]          e_ff, e_in;
   logic [7:0]             j_ff, j_in;
   logic [7:0]             start_ff, start_in;
   logic [7:0]             stop_ff, stop_in;
   logic [7:0]             end_cur_ff, end_cur_in;
   logic [7:0]             prev_ff, prev_in;
   logic                   first_ff, first_in;
   logic [5:0]             bit_ff, bit_in;
   logic [BAW-1:0]         bm_addr_ff, bm_addr_in;
   logic [7:0]             end_ff [NUM_POLYS];
   logic [7:0]             end_in [NUM_POLYS];
   logic [RSP_DATA_BITS-1:0] rsp_data_ff, rsp_data_in;
   logic                   rsp_user_ff, rsp_user_in;
   logic                   rsp_last_ff, rsp_last_in;

   logic                   sec_wr_en, sec_rd_en;
   logic [BYTE_BITS-1:0]   sec_rd_data;
   logic                   bm_wr_en, bm_rd_en;
   logic [BAW-1:0]         bm_rd_addr;
   logic [WORD_BITS-1:0]   bm_wr_data, bm_rd_data;

   logic                   req_accept;
   logic                   tail_mode;
   logic [7:0]             end_sel;

   assign req_accept = req_tvalid && (state_ff == S_LOAD);
   assign tail_mode  = (p_ff == PCW'(NUM_POLYS));
   assign end_sel    = end_ff[PW'(p_ff)];

   hvdc_ram #(
      .WIDTH(BYTE_BITS),
      .DEPTH(MAX_HINTS)
   ) u_section_ram (
      .clock   (clock),
      .wr_en   (sec_wr_en),
      .wr_addr (HAW'(cnt_ff)),
      .wr_data (req_tdata),
      .rd_en   (sec_rd_en),
      .rd_addr (HAW'(j_ff)),
      .rd_data (sec_rd_data)
   );

   hvdc_ram #(
      .WIDTH(WORD_BITS),
      .DEPTH(TOTAL_WORDS)
   ) u_bitmap_ram (
      .clock   (clock),
      .wr_en   (bm_wr_en),
      .wr_addr (bm_addr_ff),
      .wr_data (bm_wr_data),
      .rd_en   (bm_rd_en),
      .rd_addr (bm_rd_addr),
      .rd_data (bm_rd_data)
   );

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      valid_in     = valid_ff;
      err_in       = err_ff;
      rsp_valid_in = rsp_valid_ff;
      p_in         = p_ff;
      e_in         = e_ff;
      j_in         = j_ff;
      start_in     = start_ff;
      stop_in      = stop_ff;
      end_cur_in   = end_cur_ff;
      prev_in      = prev_ff;
      first_in     = first_ff;
      bit_in       = bit_ff;
      bm_addr_in   = bm_addr_ff;
      end_in       = end_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      rsp_last_in  = rsp_last_ff;
      sec_wr_en    = 1'b0;
      sec_rd_en    = 1'b0;
      bm_wr_en     = 1'b0;
      bm_rd_en     = 1'b0;
      bm_rd_addr   = BAW'(e_ff);
      bm_wr_data   = (valid_ff[bm_addr_ff] ? bm_rd_data : '0) | (64'd1 << bit_ff);

      case (state_ff)
         S_LOAD: begin
            if (req_accept) begin
               sec_wr_en = (cnt_ff < CW'(MAX_HINTS));
               for (int k = 0; k < NUM_POLYS; k++) begin
                  if (cnt_ff == CW'(MAX_HINTS + k)) begin
                     end_in[k] = req_tdata;
                  end
               end
               if (cnt_ff == CW'(SECTION_LEN - 1)) begin
                  cnt_in   = '0;
                  valid_in = '0;
                  err_in   = 1'b0;
                  start_in = '0;
                  p_in     = '0;
                  state_in = S_POLY;
               end else begin
                  cnt_in = cnt_ff + CW'(1);
               end
            end
         end
         S_POLY: begin
            j_in     = start_ff;
            first_in = 1'b1;
            if (tail_mode) begin
               stop_in = 8'(MAX_HINTS);
            end else begin
               end_cur_in = end_sel;
               if ((end_sel < start_ff) || (end_sel > 8'(MAX_HINTS))) begin
                  err_in = 1'b1;
               end
               stop_in = (end_sel > 8'(MAX_HINTS)) ? 8'(MAX_HINTS) : end_sel;
            end
            state_in = S_RD;
         end
         S_RD: begin
            if (j_ff < stop_ff) begin
               sec_rd_en = 1'b1;
               state_in  = S_POS;
            end else if (tail_mode) begin
               e_in     = '0;
               state_in = S_EMIT_RD;
            end else begin
               start_in = end_cur_ff;
               p_in     = p_ff + PCW'(1);
               state_in = S_POLY;
            end
         end
         S_POS: begin
            if (tail_mode) begin
               if (sec_rd_data != '0) begin
                  err_in = 1'b1;
               end
               j_in     = j_ff + 8'd1;
               state_in = S_RD;
            end else begin
               if (!first_ff && (sec_rd_data <= prev_ff)) begin
                  err_in = 1'b1;
               end
               prev_in    = sec_rd_data;
               first_in   = 1'b0;
               bit_in     = sec_rd_data[5:0];
               bm_rd_en   = 1'b1;
               bm_rd_addr = BAW'({p_ff, sec_rd_data[7:6]});
               bm_addr_in = BAW'({p_ff, sec_rd_data[7:6]});
               state_in   = S_UPD;
            end
         end
         S_UPD: begin
            bm_wr_en             = 1'b1;
            valid_in[bm_addr_ff] = 1'b1;
            j_in                 = j_ff + 8'd1;
            state_in             = S_RD;
         end
         S_EMIT_RD: begin
            bm_rd_en   = 1'b1;
            bm_rd_addr = BAW'(e_ff);
            state_in   = S_EMIT_LD;
         end
         S_EMIT_LD: begin
            rsp_data_in = {4'd0, e_ff[1:0], 2'(e_ff >> 2),
                           valid_ff[BAW'(e_ff)] ? bm_rd_data : '0};
            rsp_user_in  = err_ff;
            rsp_last_in  = (e_ff == EW'(TOTAL_WORDS - 1));
            rsp_valid_in = 1'b1;
            state_in     = S_EMIT_WAIT;
         end
         S_EMIT_WAIT: begin
            if (rsp_tready) begin
               rsp_valid_in = 1'b0;
               if (rsp_last_ff) begin
                  state_in = S_LOAD;
               end else begin
                  e_in     = e_ff + EW'(1);
                  state_in = S_EMIT_RD;
               end
            end
         end
         default: begin
            state_in = S_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_LOAD;
         cnt_ff       <= '0;
         valid_ff     <= '0;
         err_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
         p_ff         <= '0;
         e_ff         <= '0;
         j_ff         <= '0;
         start_ff     <= '0;
         first_ff     <= 1'b1;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         valid_ff     <= valid_in;
         err_ff       <= err_in;
         rsp_valid_ff <= rsp_valid_in;
         p_ff         <= p_in;
         e_ff         <= e_in;
         j_ff         <= j_in;
         start_ff     <= start_in;
         first_ff     <= first_in;
      end
   end

   always_ff @(posedge clock) begin
      stop_ff     <= stop_in;
      end_cur_ff  <= end_cur_in;
      prev_ff     <= prev_in;
      bit_ff      <= bit_in;
      bm_addr_ff  <= bm_addr_in;
      end_ff      <= end_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign req_tready = (state_ff == S_LOAD);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule
